@@ rtl/tilemap_scroll_strip_planner_macros.svh @@
// Assertion macros for the tile map scroll strip planner.
// Included by the modules that check their own logic; no other dependencies.
`ifndef TILEMAP_SCROLL_STRIP_PLANNER_MACROS_SVH
`define TILEMAP_SCROLL_STRIP_PLANNER_MACROS_SVH
`ifndef SYNTH
// Check a consequence in the same cycle as its cause
`define TSP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Check a consequence in the cycle after its cause
`define TSP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TSP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)
`define TSP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ rtl/tsp_pkg.sv @@
// Shared types and constants of the tile map scroll strip planner.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package tsp_pkg;

    // Fixed field widths
    localparam int CAM_W      = 11;  // camera pixel position
    localparam int TILE_W     = 8;   // tile position
    localparam int COORD_W    = 9;   // tile position plus strip offset
    localparam int SCROLL_W   = 8;
    localparam int SCR_W      = 5;   // screen map coordinate
    localparam int ADDR_W     = 16;
    localparam int LEN_W      = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int PX_SHIFT   = 3;   // 8 pixels per tile

    // Job queue depth, a power of two
    localparam int QUEUE_DEPTH = 2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_BASE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT = 2'd2;

    // Register reset values
    localparam logic [ADDR_W-1:0] MAP_BASE_RST   = 16'd0;
    localparam logic [TILE_W-1:0] MAP_WIDTH_RST  = 8'd32;
    localparam logic [TILE_W-1:0] MAP_HEIGHT_RST = 8'd32;

    typedef enum logic [1:0] {
        STRIP_NONE = 2'd0,
        STRIP_ROW  = 2'd1,
        STRIP_COL  = 2'd2
    } strip_kind_t;

    // One classified item, handed from front to back
    typedef struct packed {
        logic                is_set;
        logic                col_strip;
        logic                row_strip;
        logic                col_right;
        logic                row_bottom;
        logic [TILE_W-1:0]   tile_x;
        logic [TILE_W-1:0]   tile_y;
        logic [SCROLL_W-1:0] scroll_x;
        logic [SCROLL_W-1:0] scroll_y;
    } job_t;

    // Map geometry the back needs for addresses
    typedef struct packed {
        logic [ADDR_W-1:0] map_base;
        logic [TILE_W-1:0] row_stride;
    } map_cfg_t;

endpackage

@@ rtl/tsp_if.sv @@
// Handshake channels of the tile map scroll strip planner: request, result
// and register write. No dependencies.
`timescale 1ns / 1ps

interface tsp_req_if;
    logic              valid;
    logic              ready;
    logic              req_type;
    logic signed [7:0] step_x;
    logic signed [7:0] step_y;
    logic [15:0]       target_x;
    logic [15:0]       target_y;
    modport source (output valid, req_type, step_x, step_y, target_x, target_y,
                    input ready);
    modport sink (input valid, req_type, step_x, step_y, target_x, target_y,
                  output ready);
endinterface

interface tsp_res_if;
    logic        valid;
    logic        ready;
    logic [7:0]  scroll_x;
    logic [7:0]  scroll_y;
    logic [1:0]  strip_kind;
    logic [4:0]  screen_tile_x;
    logic [4:0]  screen_tile_y;
    logic [15:0] source_addr;
    logic [4:0]  strip_length;
    logic        last;
    modport source (output valid, scroll_x, scroll_y, strip_kind, screen_tile_x,
                    screen_tile_y, source_addr, strip_length, last,
                    input ready);
    modport sink (input valid, scroll_x, scroll_y, strip_kind, screen_tile_x,
                  screen_tile_y, source_addr, strip_length, last,
                  output ready);
endinterface

interface tsp_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/tilemap_scroll_strip_planner.sv @@
// Top level of the tile map scroll strip planner: front, job queue and back.
// Depends on tsp_pkg, tsp_if, tsp_front, tsp_queue and tsp_back.
`timescale 1ns / 1ps

// Tile map scroll strip planner. Register writes go through cfg and take
// effect at once; write them only while no item is in flight. Each request
// item (relative move or absolute set) moves the camera at the front and is
// queued as a job; the front takes one item a clock while the two-entry job
// queue has room. The back issues one strip result a clock through its
// sequencer while res is ready, so a move yields one or two results and a
// set yields SCREEN_TILES_H+4 (22 at the defaults); that result issue sets the
// sustained rate. The first result of an item passes the queue, the job load,
// the issue register, the stride multiply and the address add before res.
module tilemap_scroll_strip_planner import tsp_pkg::*;
#(
    parameter int SCREEN_TILES_W = 20,
    parameter int SCREEN_TILES_H = 18,
    parameter int HW_MAP_SIZE    = 32
)
(
    input  logic      clk,
    input  logic      rst_n,
    tsp_cfg_if.sink   cfg,
    tsp_req_if.sink   req,
    tsp_res_if.source res
);

    job_t     front_job;
    logic     front_job_valid;
    logic     front_job_ready;
    job_t     back_job;
    logic     back_job_valid;
    logic     back_job_ready;
    map_cfg_t map_cfg;

    // Camera, registers and classification
    tsp_front #(
        .SCREEN_TILES_W (SCREEN_TILES_W),
        .SCREEN_TILES_H (SCREEN_TILES_H)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .req       (req),
        .job_valid (front_job_valid),
        .job_ready (front_job_ready),
        .job       (front_job),
        .map_cfg   (map_cfg)
    );

    // Decouple the two sides
    tsp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_job_valid),
        .push_ready (front_job_ready),
        .push_data  (front_job),
        .pop_valid  (back_job_valid),
        .pop_ready  (back_job_ready),
        .pop_data   (back_job)
    );

    // Strip sequencing and addresses
    tsp_back #(
        .SCREEN_TILES_W (SCREEN_TILES_W),
        .SCREEN_TILES_H (SCREEN_TILES_H),
        .HW_MAP_SIZE    (HW_MAP_SIZE)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (back_job_valid),
        .job_ready (back_job_ready),
        .job       (back_job),
        .map_cfg   (map_cfg),
        .res       (res)
    );

endmodule

@@ rtl/tsp_queue.sv @@
// Short job queue between the front and the back of the strip planner.
// Depends on tsp_pkg (job_t, QUEUE_DEPTH) and the assertion macros.
`timescale 1ns / 1ps
`include "tilemap_scroll_strip_planner_macros.svh"

module tsp_queue import tsp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  job_t push_data,
    output logic pop_valid,
    input  logic pop_ready,
    output job_t pop_data
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(QUEUE_DEPTH);

    job_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push;
    logic             pop;

    // Handshake and pointer advance
    always_comb
    begin
        push_ready  = (count_reg != FULL_COUNT);
        pop_valid   = (count_reg != '0);
        pop_data    = entry_reg[rd_ptr_reg];
        push        = push_valid && push_ready;
        pop         = pop_valid && pop_ready;
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Hold pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store pushed jobs
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    `TSP_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_reg <= FULL_COUNT, "queue overfilled")
    `TSP_ASSERT_NEXT(a_count_up, clk, rst_n, push && !pop, count_reg == $past(count_reg) + 1'b1, "push lost")
    `TSP_ASSERT_NEXT(a_count_down, clk, rst_n, pop && !push, count_reg == $past(count_reg) - 1'b1, "pop lost")

endmodule

@@ rtl/tsp_front.sv @@
// Front of the strip planner: holds the registers and the camera, takes
// request items and classifies each into a job. Depends on tsp_pkg, tsp_if.
`timescale 1ns / 1ps

module tsp_front import tsp_pkg::*;
#(
    parameter int SCREEN_TILES_W = 20,
    parameter int SCREEN_TILES_H = 18
)
(
    input  logic       clk,
    input  logic       rst_n,
    tsp_cfg_if.sink    cfg,
    tsp_req_if.sink    req,
    output logic       job_valid,
    input  logic       job_ready,
    output job_t       job,
    output map_cfg_t   map_cfg
);

    localparam logic [CAM_W-1:0] SCR_PX_X = CAM_W'(SCREEN_TILES_W << PX_SHIFT);
    localparam logic [CAM_W-1:0] SCR_PX_Y = CAM_W'(SCREEN_TILES_H << PX_SHIFT);

    // Largest camera position for a map size; zero when the map is narrower
    function automatic logic [CAM_W-1:0] cam_max(input logic [TILE_W-1:0] tiles,
                                                 input logic [CAM_W-1:0] scr_px);
        logic [CAM_W-1:0] map_px;
        map_px = CAM_W'(tiles) << PX_SHIFT;
        return (map_px > scr_px) ? map_px - scr_px : '0;
    endfunction

    // Top-left visible tile less a one-tile border
    function automatic logic [TILE_W-1:0] tile_of(input logic [CAM_W-1:0] cam);
        logic [TILE_W-1:0] t;
        t = cam[CAM_W-1:PX_SHIFT];
        return (t != '0) ? t - 1'b1 : '0;
    endfunction

    // Add a signed step, stop at zero and at the maximum
    function automatic logic [CAM_W-1:0] move_axis(input logic [CAM_W-1:0] cam,
                                                   input logic signed [7:0] step,
                                                   input logic [CAM_W-1:0] max);
        logic signed [CAM_W+1:0] sum;
        sum = $signed({2'b00, cam}) + (CAM_W + 2)'(step);
        if (sum[CAM_W+1])
        begin
            return '0;
        end
        else if (sum[CAM_W:0] > {1'b0, max})
        begin
            return max;
        end
        return sum[CAM_W-1:0];
    endfunction

    // Clamp an absolute target to the maximum
    function automatic logic [CAM_W-1:0] clamp_target(input logic [15:0] target,
                                                      input logic [CAM_W-1:0] max);
        return (target > 16'(max)) ? max : target[CAM_W-1:0];
    endfunction

    logic [ADDR_W-1:0] map_base_reg;
    logic [TILE_W-1:0] row_stride_reg;
    logic [CAM_W-1:0]  max_x_reg;
    logic [CAM_W-1:0]  max_y_reg;
    logic [CAM_W-1:0]  cam_x_reg, cam_x_next;
    logic [CAM_W-1:0]  cam_y_reg, cam_y_next;
    logic [TILE_W-1:0] prev_tile_x_reg, prev_tile_x_next;
    logic [TILE_W-1:0] prev_tile_y_reg, prev_tile_y_next;
    logic              accept;

    // Work out the new camera and classify the item
    always_comb
    begin
        req.ready = job_ready;
        cfg.ready = 1'b1;
        accept    = req.valid && req.ready;
        if (req.req_type)
        begin
            cam_x_next = clamp_target(req.target_x, max_x_reg);
            cam_y_next = clamp_target(req.target_y, max_y_reg);
        end
        else
        begin
            cam_x_next = move_axis(cam_x_reg, req.step_x, max_x_reg);
            cam_y_next = move_axis(cam_y_reg, req.step_y, max_y_reg);
        end
        prev_tile_x_next = tile_of(cam_x_next);
        prev_tile_y_next = tile_of(cam_y_next);

        job_valid      = accept;
        job.is_set     = req.req_type;
        job.col_strip  = !req.req_type && (prev_tile_x_next != prev_tile_x_reg);
        job.row_strip  = !req.req_type && (prev_tile_y_next != prev_tile_y_reg);
        job.col_right  = (req.step_x > 8'sd0);
        job.row_bottom = (req.step_y > 8'sd0);
        job.tile_x     = prev_tile_x_next;
        job.tile_y     = prev_tile_y_next;
        job.scroll_x   = cam_x_next[SCROLL_W-1:0];
        job.scroll_y   = cam_y_next[SCROLL_W-1:0];

        map_cfg.map_base   = map_base_reg;
        map_cfg.row_stride = row_stride_reg;
    end

    // Hold registers, camera and last tile
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_base_reg    <= MAP_BASE_RST;
            row_stride_reg  <= MAP_WIDTH_RST;
            max_x_reg       <= cam_max(MAP_WIDTH_RST, SCR_PX_X);
            max_y_reg       <= cam_max(MAP_HEIGHT_RST, SCR_PX_Y);
            cam_x_reg       <= '0;
            cam_y_reg       <= '0;
            prev_tile_x_reg <= '0;
            prev_tile_y_reg <= '0;
        end
        else
        begin
            if (cfg.valid)
            begin
                case (cfg.index)
                    CFG_MAP_BASE:
                    begin
                        map_base_reg <= cfg.data;
                    end
                    CFG_MAP_WIDTH:
                    begin
                        row_stride_reg <= cfg.data[TILE_W-1:0];
                        max_x_reg      <= cam_max(cfg.data[TILE_W-1:0], SCR_PX_X);
                    end
                    CFG_MAP_HEIGHT:
                    begin
                        max_y_reg <= cam_max(cfg.data[TILE_W-1:0], SCR_PX_Y);
                    end
                    default:
                    begin
                        // unmapped index: drop the write
                    end
                endcase
            end
            if (accept)
            begin
                cam_x_reg       <= cam_x_next;
                cam_y_reg       <= cam_y_next;
                prev_tile_x_reg <= prev_tile_x_next;
                prev_tile_y_reg <= prev_tile_y_next;
            end
        end
    end

endmodule

@@ rtl/tsp_back.sv @@
// Back of the strip planner: turns each job into strip results through a
// sequencer and a three-stage address pipeline. Depends on tsp_pkg, tsp_if.
`timescale 1ns / 1ps
`include "tilemap_scroll_strip_planner_macros.svh"

module tsp_back import tsp_pkg::*;
#(
    parameter int SCREEN_TILES_W = 20,
    parameter int SCREEN_TILES_H = 18,
    parameter int HW_MAP_SIZE    = 32
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      job_valid,
    output logic      job_ready,
    input  job_t      job,
    input  map_cfg_t  map_cfg,
    tsp_res_if.source res
);

    localparam int ROWS  = SCREEN_TILES_H + 4;
    localparam int IDX_W = $clog2(ROWS);
    localparam logic [IDX_W-1:0]   LAST_IDX       = IDX_W'(ROWS - 1);
    localparam logic [LEN_W-1:0]   ROW_LEN        = LEN_W'(SCREEN_TILES_W + 3);
    localparam logic [LEN_W-1:0]   COL_LEN        = LEN_W'(SCREEN_TILES_H + 4);
    localparam logic [COORD_W-1:0] COL_RIGHT_OFF  = COORD_W'(SCREEN_TILES_W + 2);
    localparam logic [COORD_W-1:0] ROW_BOTTOM_OFF = COORD_W'(SCREEN_TILES_H + 2);
    localparam logic [SCR_W-1:0]   SCR_MASK       = SCR_W'(HW_MAP_SIZE - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COL,
        ST_ROW,
        ST_NONE,
        ST_SET
    } state_t;

    // Issued strip, before the address is formed
    typedef struct packed {
        strip_kind_t         kind;
        logic [SCROLL_W-1:0] scroll_x;
        logic [SCROLL_W-1:0] scroll_y;
        logic [COORD_W-1:0]  row;
        logic [COORD_W-1:0]  col;
        logic [LEN_W-1:0]    len;
        logic                last;
    } seq_t;

    // Strip with the row offset multiplied out
    typedef struct packed {
        strip_kind_t         kind;
        logic [SCROLL_W-1:0] scroll_x;
        logic [SCROLL_W-1:0] scroll_y;
        logic [SCR_W-1:0]    sx;
        logic [SCR_W-1:0]    sy;
        logic [ADDR_W-1:0]   prod;
        logic [COORD_W-1:0]  col;
        logic [LEN_W-1:0]    len;
        logic                last;
    } mul_t;

    typedef struct packed {
        strip_kind_t         kind;
        logic [SCROLL_W-1:0] scroll_x;
        logic [SCROLL_W-1:0] scroll_y;
        logic [SCR_W-1:0]    sx;
        logic [SCR_W-1:0]    sy;
        logic [ADDR_W-1:0]   addr;
        logic [LEN_W-1:0]    len;
        logic                last;
    } out_t;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] row_idx_reg, row_idx_next;
    job_t             job_reg;
    seq_t             s1_reg, s1_next;
    mul_t             s2_reg, s2_next;
    out_t             out_reg, out_next;
    logic             s1_valid_reg, s2_valid_reg, out_valid_reg;
    logic             out_adv, s2_free, s1_free;
    logic             issue, issue_last, load;

    function automatic state_t first_state(input job_t j);
        if (j.is_set)
        begin
            return ST_SET;
        end
        else if (j.col_strip)
        begin
            return ST_COL;
        end
        else if (j.row_strip)
        begin
            return ST_ROW;
        end
        return ST_NONE;
    endfunction

    // Pipeline flow: a stage moves on when the one after it has room
    always_comb
    begin
        out_adv = !out_valid_reg || res.ready;
        s2_free = !s2_valid_reg || out_adv;
        s1_free = !s1_valid_reg || s2_free;
        issue   = (state_reg != ST_IDLE) && s1_free;
    end

    // Sequence the strips of the current job
    always_comb
    begin
        s1_next.kind     = STRIP_NONE;
        s1_next.scroll_x = job_reg.scroll_x;
        s1_next.scroll_y = job_reg.scroll_y;
        s1_next.row      = '0;
        s1_next.col      = '0;
        s1_next.len      = '0;
        s1_next.last     = 1'b1;
        case (state_reg)
            ST_COL:
            begin
                s1_next.kind = STRIP_COL;
                s1_next.row  = COORD_W'(job_reg.tile_y);
                s1_next.col  = COORD_W'(job_reg.tile_x)
                             + (job_reg.col_right ? COL_RIGHT_OFF : '0);
                s1_next.len  = COL_LEN;
                s1_next.last = !job_reg.row_strip;
            end
            ST_ROW:
            begin
                s1_next.kind = STRIP_ROW;
                s1_next.row  = COORD_W'(job_reg.tile_y)
                             + (job_reg.row_bottom ? ROW_BOTTOM_OFF : '0);
                s1_next.col  = COORD_W'(job_reg.tile_x);
                s1_next.len  = ROW_LEN;
            end
            ST_SET:
            begin
                s1_next.kind = STRIP_ROW;
                s1_next.row  = COORD_W'(job_reg.tile_y) + COORD_W'(row_idx_reg);
                s1_next.col  = COORD_W'(job_reg.tile_x);
                s1_next.len  = ROW_LEN;
                s1_next.last = (row_idx_reg == LAST_IDX);
            end
            default:
            begin
                // idle or no strip: keep the empty result
            end
        endcase
        issue_last = issue && s1_next.last;
        job_ready  = (state_reg == ST_IDLE) || issue_last;
        load       = job_valid && job_ready;

        state_next   = state_reg;
        row_idx_next = row_idx_reg;
        if (load)
        begin
            state_next   = first_state(job);
            row_idx_next = '0;
        end
        else if (issue_last)
        begin
            state_next = ST_IDLE;
        end
        else if (issue)
        begin
            if (state_reg == ST_COL)
            begin
                state_next = ST_ROW;
            end
            row_idx_next = row_idx_reg + 1'b1;
        end
    end

    // Multiply the row by the stride, then form the address
    always_comb
    begin
        s2_next.kind     = s1_reg.kind;
        s2_next.scroll_x = s1_reg.scroll_x;
        s2_next.scroll_y = s1_reg.scroll_y;
        s2_next.sx       = s1_reg.col[SCR_W-1:0] & SCR_MASK;
        s2_next.sy       = s1_reg.row[SCR_W-1:0] & SCR_MASK;
        s2_next.prod     = ADDR_W'(s1_reg.row) * ADDR_W'(map_cfg.row_stride);
        s2_next.col      = s1_reg.col;
        s2_next.len      = s1_reg.len;
        s2_next.last     = s1_reg.last;

        out_next.kind     = s2_reg.kind;
        out_next.scroll_x = s2_reg.scroll_x;
        out_next.scroll_y = s2_reg.scroll_y;
        out_next.sx       = s2_reg.sx;
        out_next.sy       = s2_reg.sy;
        out_next.addr     = (s2_reg.kind == STRIP_NONE) ? '0
                          : map_cfg.map_base + s2_reg.prod + ADDR_W'(s2_reg.col);
        out_next.len      = s2_reg.len;
        out_next.last     = s2_reg.last;
    end

    // Hold state, stage valids and the result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            row_idx_reg   <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            row_idx_reg <= row_idx_next;
            if (s1_free)
            begin
                s1_valid_reg <= issue;
            end
            if (s2_free)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (out_adv)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    // Advance payloads
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            job_reg <= job;
        end
        if (s1_free)
        begin
            s1_reg <= s1_next;
        end
        if (s2_free)
        begin
            s2_reg <= s2_next;
        end
        if (out_adv)
        begin
            out_reg <= out_next;
        end
    end

    assign res.valid         = out_valid_reg;
    assign res.scroll_x      = out_reg.scroll_x;
    assign res.scroll_y      = out_reg.scroll_y;
    assign res.strip_kind    = out_reg.kind;
    assign res.screen_tile_x = out_reg.sx;
    assign res.screen_tile_y = out_reg.sy;
    assign res.source_addr   = out_reg.addr;
    assign res.strip_length  = out_reg.len;
    assign res.last          = out_reg.last;

    `TSP_ASSERT_NEXT(a_load_busy, clk, rst_n, load, state_reg != ST_IDLE,
                     "job taken but sequencer idle")
    `TSP_ASSERT_NOW(a_col_job, clk, rst_n, state_reg == ST_COL,
                    job_reg.col_strip && !job_reg.is_set, "column strip without a column job")
    `TSP_ASSERT_NOW(a_set_idx, clk, rst_n, state_reg == ST_SET, row_idx_reg <= LAST_IDX,
                    "redraw ran past the last row")
    `TSP_ASSERT_NOW(a_none_last, clk, rst_n, s1_valid_reg && s1_reg.kind == STRIP_NONE,
                    s1_reg.last && s1_reg.len == '0, "empty result not final")

endmodule
